[sv/double_to_five_byte_float_defines.svh]
// Assertion macros for the double to five-byte float converter.
// Used by the checker module only.
`ifndef DOUBLE_TO_FIVE_BYTE_FLOAT_DEFINES_SVH
`define DOUBLE_TO_FIVE_BYTE_FLOAT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define D2F_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the next clock edge.
`define D2F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/d2f_pkg.sv]
// Package for the double to five-byte float converter: types and constants.
// No dependencies.
`timescale 1ns / 1ps

package d2f_pkg;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusNan   = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  localparam logic [10:0] ExpAllOnes = 11'h7FF;
  localparam logic [10:0] ExpBias    = 11'd1075;

  typedef struct packed {
    logic [7:0] exponent_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [7:0] fifth_byte;
    logic [1:0] status;
  } result_t;

  // Lead-one position of a 52-bit fraction (0 when empty).
  function automatic logic [5:0] lead_one(input logic [51:0] fr);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (fr[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

[sv/d2f_if.sv]
// Valid/ready channel interfaces for the converter.
// No dependencies.
`timescale 1ns / 1ps

interface d2f_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

interface d2f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] exponent_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] fourth_byte;
  logic [7:0] fifth_byte;
  logic [1:0] status;
  modport source (output valid, output exponent_byte, output second_byte,
                  output third_byte, output fourth_byte, output fifth_byte,
                  output status, input ready);
  modport sink   (input valid, input exponent_byte, input second_byte,
                  input third_byte, input fourth_byte, input fifth_byte,
                  input status, output ready);
endinterface

[sv/d2f_core.sv]
// Three-stage conversion datapath with per-stage valid and global enable.
// Depends on d2f_pkg.
`timescale 1ns / 1ps

module d2f_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_bits,
  output logic              out_valid,
  output d2f_pkg::result_t  out_res
);

  // stage 1: decode and normalize
  logic        v1;
  logic        s1_neg, s1_special, s1_zero, s1_int;
  logic [52:0] s1_sig;
  logic [11:0] s1_e2;
  logic [16:0] s1_whole;

  logic [10:0] ex;
  logic [51:0] fr;
  logic [5:0]  p;
  logic [10:0] sh;
  logic [52:0] sig_n, mask;
  logic [52:0] whole_full;
  logic        int_ok;

  always_comb begin
    ex = in_bits[62:52];
    fr = in_bits[51:0];
    p  = d2f_pkg::lead_one(fr);
    sh = d2f_pkg::ExpBias - ex;
    sig_n = {1'b1, fr};
    int_ok = 1'b0;
    whole_full = '0;
    mask = '0;
    if (ex != 11'd0 && ex < d2f_pkg::ExpBias && sh <= 11'd53) begin
      whole_full = sig_n >> sh[5:0];
      mask = (sh == 11'd53) ? {53{1'b1}} : ((53'd1 << sh[5:0]) - 53'd1);
      int_ok = ((sig_n & mask) == '0) && (whole_full <= 53'd65535);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      s1_neg     <= in_bits[63];
      s1_special <= (ex == d2f_pkg::ExpAllOnes);
      s1_zero    <= (ex == 11'd0) && (fr == '0);
      s1_int     <= int_ok;
      s1_whole   <= whole_full[16:0];
      if (ex != 11'd0) begin
        s1_sig <= sig_n;
        s1_e2  <= 12'({1'b0, ex}) - 12'd1022;
      end else begin
        s1_sig <= 53'({1'b0, fr} << (6'd52 - p));
        s1_e2  <= 12'({6'd0, p}) - 12'd1073;
      end
    end
  end

  // stage 2: round mantissa
  logic        v2;
  logic        s2_neg, s2_special, s2_zero, s2_int;
  logic [16:0] s2_whole;
  logic [32:0] s2_mant;
  logic [11:0] s2_e2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      s2_neg     <= s1_neg;
      s2_special <= s1_special;
      s2_zero    <= s1_zero;
      s2_int     <= s1_int;
      s2_whole   <= s1_whole;
      s2_mant    <= 33'((54'(s1_sig) + 54'(1 << 20)) >> 21);
      s2_e2      <= s1_e2;
    end
  end

  // stage 3: pack
  logic [31:0] mant;
  logic [11:0] e2;
  logic [15:0] u;
  d2f_pkg::result_t r;

  always_comb begin
    mant = s2_mant[31:0];
    e2   = s2_e2;
    if (s2_mant[32]) begin
      mant = 32'h8000_0000;
      e2   = s2_e2 + 12'd1;
    end
    u = s2_neg ? (16'd0 - s2_whole[15:0]) : s2_whole[15:0];
    r = '0;
    if (s2_special) begin
      r.status = d2f_pkg::StatusNan;
    end else if (s2_zero) begin
      r.status = d2f_pkg::StatusOk;
    end else if (s2_int) begin
      r.second_byte = (s2_neg && s2_whole != '0) ? 8'hFF : 8'h00;
      r.third_byte  = u[7:0];
      r.fourth_byte = u[15:8];
    end else begin
      r.exponent_byte = e2[7:0] + 8'h80;
      r.second_byte   = {s2_neg, mant[30:24]};
      r.third_byte    = mant[23:16];
      r.fourth_byte   = mant[15:8];
      r.fifth_byte    = mant[7:0];
      // signed range check: -127..127
      r.status = ($signed(e2) < -12'sd127 || $signed(e2) > 12'sd127)
                 ? d2f_pkg::StatusRange : d2f_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
    if (en) out_res <= r;
  end

endmodule

[sv/double_to_five_byte_float.sv]
// Pipeline: 3 register stages; a word accepted into the decode register
// passes through the round and pack registers before its result shows.
// Throughput: one word per cycle; the decode, round and pack stages each
// hold one word and advance together when the output is free or taken.
// Reset: rst (synchronous, active high) clears all stage valid bits.
`timescale 1ns / 1ps

module double_to_five_byte_float (
  input  logic       clk,
  input  logic       rst,
  d2f_in_if.sink     in_ch,
  d2f_out_if.source  out_ch
);

  logic             en;
  logic             vout;
  d2f_pkg::result_t res;

  // pipeline advances unless a held result is stalled
  assign en = out_ch.ready || !vout;
  assign in_ch.ready = en;

  d2f_core u_core (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_ch.valid), .in_bits(in_ch.value_bits),
    .out_valid(vout), .out_res(res)
  );

  assign out_ch.valid         = vout;
  assign out_ch.exponent_byte = res.exponent_byte;
  assign out_ch.second_byte   = res.second_byte;
  assign out_ch.third_byte    = res.third_byte;
  assign out_ch.fourth_byte   = res.fourth_byte;
  assign out_ch.fifth_byte    = res.fifth_byte;
  assign out_ch.status        = res.status;

endmodule

[sv/d2f_checker.sv]
// Port-level checker for the converter, bound to the top level.
// Depends on double_to_five_byte_float_defines.svh.
`timescale 1ns / 1ps
`include "double_to_five_byte_float_defines.svh"

module d2f_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] b0, b1, b2, b3, b4,
  input logic [1:0] st
);

  `D2F_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(b1),
    "stalled word changed")
  `D2F_ASSERT_IMPL(a_nan_zero, out_valid && st == 2'd1,
    b0 == 0 && b1 == 0 && b2 == 0 && b3 == 0 && b4 == 0, "NaN word not zero")
  `D2F_ASSERT_IMPL(a_status, out_valid, st != 2'd3, "bad status")
  // in-range float form never has a zero exponent byte
  `D2F_ASSERT_IMPL(a_int_fifth, out_valid && b0 == 0 && st == 2'd0, b4 == 0,
    "int form fifth byte")
  `D2F_ASSERT_IMPL(a_ready, !out_valid, in_ready, "idle pipe not ready")

endmodule

bind double_to_five_byte_float d2f_checker u_chk (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .b0(out_ch.exponent_byte), .b1(out_ch.second_byte), .b2(out_ch.third_byte),
  .b3(out_ch.fourth_byte), .b4(out_ch.fifth_byte), .st(out_ch.status)
);
